// ===== hdl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types, constants and helpers of the request head parser
// ----------------------------------------------------------------------------
`default_nettype none
package hrhp_pkg;

    localparam int unsigned LENGTH_WIDTH_DEF = 16;
    localparam logic [15:0] MAX_BODY_RESET   = 16'd4096;

    typedef enum logic [3:0] {
        PH_METHOD = 4'd0,
        PH_PATH0  = 4'd1,
        PH_PATH   = 4'd2,
        PH_VER    = 4'd3,
        PH_SLLF   = 4'd4,
        PH_KEY0   = 4'd5,
        PH_KEY    = 4'd6,
        PH_SPC    = 4'd7,
        PH_VAL0   = 4'd8,
        PH_VAL    = 4'd9,
        PH_LINELF = 4'd10,
        PH_ENDLF  = 4'd11,
        PH_BODY   = 4'd12
    } t_phase;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LINE = 3'd1;
    localparam logic [2:0] ST_BAD_HDR  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    localparam logic [2:0] PT_DELIM  = 3'd0;
    localparam logic [2:0] PT_METHOD = 3'd1;
    localparam logic [2:0] PT_PATH   = 3'd2;
    localparam logic [2:0] PT_VER    = 3'd3;
    localparam logic [2:0] PT_KEY    = 3'd4;
    localparam logic [2:0] PT_VALUE  = 3'd5;
    localparam logic [2:0] PT_BODY   = 3'd6;

    localparam logic [1:0] HC_OTHER  = 2'd0;
    localparam logic [1:0] HC_CTYPE  = 2'd1;
    localparam logic [1:0] HC_CLEN   = 2'd2;
    localparam logic [1:0] HC_HOST   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic        done_res;
        logic [2:0]  status_code;
        logic        method;
        logic [2:0]  part;
        logic [1:0]  header_class;
        logic [15:0] content_length;
        logic [7:0]  byte_out;
    } t_out_item;

    function automatic logic is_delim(input logic [7:0] c);
        return c == 8'h20 || c == 8'h3A || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic [7:0] get_char(input logic [3:0] p);
        unique case (p)
            4'd0: return "G";
            4'd1: return "E";
            4'd2: return "T";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] post_char(input logic [3:0] p);
        unique case (p)
            4'd0: return "P";
            4'd1: return "O";
            4'd2: return "S";
            4'd3: return "T";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [3:0] p);
        unique case (p)
            4'd0: return "H";
            4'd1: return "T";
            4'd2: return "T";
            4'd3: return "P";
            4'd4: return "/";
            4'd5: return "1";
            4'd6: return ".";
            4'd7: return "1";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ctype_char(input logic [3:0] p);
        unique case (p)
            4'd0: return "C";
            4'd1: return "o";
            4'd2: return "n";
            4'd3: return "t";
            4'd4: return "e";
            4'd5: return "n";
            4'd6: return "t";
            4'd7: return "-";
            4'd8: return "T";
            4'd9: return "y";
            4'd10: return "p";
            4'd11: return "e";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] p);
        unique case (p)
            4'd0: return "C";
            4'd1: return "o";
            4'd2: return "n";
            4'd3: return "t";
            4'd4: return "e";
            4'd5: return "n";
            4'd6: return "t";
            4'd7: return "-";
            4'd8: return "L";
            4'd9: return "e";
            4'd10: return "n";
            4'd11: return "g";
            4'd12: return "t";
            4'd13: return "h";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] host_char(input logic [3:0] p);
        unique case (p)
            4'd0: return "H";
            4'd1: return "o";
            4'd2: return "s";
            4'd3: return "t";
            default: return 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hrhp_len_acc.sv =====
// ----------------------------------------------------------------------------
// hrhp_len_acc
// decimal length digit step: accum times ten plus digit, saturating
// ----------------------------------------------------------------------------
`default_nettype none
module hrhp_len_acc #(
    parameter int unsigned LENGTH_WIDTH = hrhp_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic [LENGTH_WIDTH-1:0] i_accum,
    input  wire logic [3:0]              i_digit,
    output logic      [LENGTH_WIDTH-1:0] o_next
);
    logic [LENGTH_WIDTH+4:0] w_prod;

    always_comb begin
        w_prod = ({5'd0, i_accum} << 3) + ({5'd0, i_accum} << 1)
               + {{(LENGTH_WIDTH+1){1'b0}}, i_digit};
        if (w_prod[LENGTH_WIDTH+4:LENGTH_WIDTH] != 5'd0) begin
            o_next = {LENGTH_WIDTH{1'b1}};
        end else begin
            o_next = w_prod[LENGTH_WIDTH-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/http_request_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser
// checks an http/1.1 request head byte by byte, tags bytes, counts the body
// ----------------------------------------------------------------------------
// channel  direction  handshake        payload
// in       input      i_valid/o_stall  i_in   (t_in_item)
// out      output     o_valid/i_stall  o_out  (t_out_item)
// cfg      input      i_cfg_we         i_cfg_data (max_body)
//
// one byte per cycle while the out channel is not stalled; every transfer in gives one transfer out
// parser state and result register update at the edge that takes a byte in
// a stalled result holds in the output register while one more byte waits
// in a skid register; o_stall rises only when that skid register is full
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
module http_request_head_parser #(
    parameter int unsigned LENGTH_WIDTH = hrhp_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire hrhp_pkg::t_in_item   i_in,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output hrhp_pkg::t_out_item       o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_data
);
    localparam logic [LENGTH_WIDTH-1:0] ZERO_L = '0;
    localparam logic [LENGTH_WIDTH-1:0] ONE_L  = LENGTH_WIDTH'(1);

    hrhp_pkg::t_phase        r_phase, n_phase;
    logic [3:0]              r_mpos, n_mpos;
    logic                    r_meth, n_meth;
    logic [2:0]              r_cand, n_cand;
    logic [1:0]              r_cls, n_cls;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [LENGTH_WIDTH-1:0] r_acc, n_acc;
    logic                    r_neg, n_neg, r_dig, n_dig, r_stop, n_stop;
    logic [LENGTH_WIDTH-1:0] r_rem, n_rem;
    logic [15:0]             r_max_body;

    logic                    r_skid_v;
    hrhp_pkg::t_in_item      r_skid;
    logic                    r_out_v;
    hrhp_pkg::t_out_item     r_out;

    hrhp_pkg::t_in_item      w_item;
    logic                    w_go;
    hrhp_pkg::t_out_item     w_res;
    logic [7:0]              b;
    logic                    w_isdig;
    logic [LENGTH_WIDTH-1:0] w_accx;
    logic                    w_fin;
    logic [2:0]              w_st;
    logic [2:0]              w_part;
    logic                    w_lenok;
    logic [3:0]              w_mp1;

    hrhp_len_acc #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_acc (
        .i_accum (r_acc),
        .i_digit (b[3:0]),
        .o_next  (w_accx)
    );

    assign w_item  = r_skid_v ? r_skid : i_in;
    assign w_go    = (r_skid_v || i_valid) && (!r_out_v || !i_stall);
    assign o_stall = r_skid_v;
    assign o_valid = r_out_v;
    assign o_out   = r_out;
    assign b       = w_item.end_of_stream ? 8'h00 : w_item.data_byte;
    assign w_isdig = b >= "0" && b <= "9";
    assign w_mp1   = (r_mpos == 4'd15) ? 4'd15 : r_mpos + 4'd1;

    always_comb begin
        n_phase = r_phase; n_mpos = r_mpos; n_meth = r_meth; n_cand = r_cand;
        n_cls = r_cls; n_len = r_len; n_acc = r_acc; n_neg = r_neg;
        n_dig = r_dig; n_stop = r_stop; n_rem = r_rem;
        w_fin = 1'b0; w_st = hrhp_pkg::ST_OK; w_part = hrhp_pkg::PT_DELIM;
        w_lenok = 1'b1;
        if (w_item.end_of_stream) begin
            w_fin = 1'b1;
            if (r_phase <= hrhp_pkg::PH_SLLF) w_st = hrhp_pkg::ST_BAD_LINE;
            else if (r_phase == hrhp_pkg::PH_BODY) w_st = hrhp_pkg::ST_SHORT;
            else w_st = hrhp_pkg::ST_BAD_HDR;
        end else begin
            unique case (r_phase)
                hrhp_pkg::PH_METHOD: begin
                    if (r_mpos == 4'd0) begin
                        if (b == "G") begin
                            n_meth = 1'b0; n_mpos = 4'd1; w_part = hrhp_pkg::PT_METHOD;
                        end else if (b == "P") begin
                            n_meth = 1'b1; n_mpos = 4'd1; w_part = hrhp_pkg::PT_METHOD;
                        end else begin
                            w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                        end
                    end else if (r_mpos < (r_meth ? 4'd4 : 4'd3)) begin
                        if (b == (r_meth ? hrhp_pkg::post_char(r_mpos)
                                         : hrhp_pkg::get_char(r_mpos))) begin
                            n_mpos = r_mpos + 4'd1; w_part = hrhp_pkg::PT_METHOD;
                        end else begin
                            w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                        end
                    end else if (b == 8'h20) begin
                        n_phase = hrhp_pkg::PH_PATH0; n_mpos = 4'd0;
                    end else begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                    end
                end
                hrhp_pkg::PH_PATH0: begin
                    if (hrhp_pkg::is_delim(b)) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                    end else begin
                        n_phase = hrhp_pkg::PH_PATH; w_part = hrhp_pkg::PT_PATH;
                    end
                end
                hrhp_pkg::PH_PATH: begin
                    if (b == 8'h20) begin
                        n_phase = hrhp_pkg::PH_VER; n_mpos = 4'd0;
                    end else if (hrhp_pkg::is_delim(b)) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                    end else begin
                        w_part = hrhp_pkg::PT_PATH;
                    end
                end
                hrhp_pkg::PH_VER: begin
                    if (r_mpos < 4'd8) begin
                        if (b == hrhp_pkg::ver_char(r_mpos)) begin
                            n_mpos = r_mpos + 4'd1; w_part = hrhp_pkg::PT_VER;
                        end else begin
                            w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                        end
                    end else if (b == 8'h0D) begin
                        n_phase = hrhp_pkg::PH_SLLF;
                    end else begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                    end
                end
                hrhp_pkg::PH_SLLF: begin
                    if (b == 8'h0A) n_phase = hrhp_pkg::PH_KEY0;
                    else begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                    end
                end
                hrhp_pkg::PH_KEY0: begin
                    if (b == 8'h0D) n_phase = hrhp_pkg::PH_ENDLF;
                    else if (hrhp_pkg::is_delim(b)) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                    end else begin
                        n_cls = hrhp_pkg::HC_OTHER;
                        n_cand = {b == "H", b == "C", b == "C"};
                        n_mpos = 4'd1;
                        n_phase = hrhp_pkg::PH_KEY; w_part = hrhp_pkg::PT_KEY;
                    end
                end
                hrhp_pkg::PH_KEY: begin
                    if (b == 8'h3A) begin
                        n_cls = hrhp_pkg::HC_OTHER;
                        if (r_cand[0] && r_mpos == 4'd12) n_cls = hrhp_pkg::HC_CTYPE;
                        if (r_cand[1] && r_mpos == 4'd14) n_cls = hrhp_pkg::HC_CLEN;
                        if (r_cand[2] && r_mpos == 4'd4)  n_cls = hrhp_pkg::HC_HOST;
                        n_neg = 1'b0; n_dig = 1'b0; n_stop = 1'b0; n_acc = ZERO_L;
                        n_phase = hrhp_pkg::PH_SPC;
                    end else if (hrhp_pkg::is_delim(b)) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                    end else begin
                        n_cand[0] = r_cand[0] && r_mpos < 4'd12
                                    && b == hrhp_pkg::ctype_char(r_mpos);
                        n_cand[1] = r_cand[1] && r_mpos < 4'd14
                                    && b == hrhp_pkg::clen_char(r_mpos);
                        n_cand[2] = r_cand[2] && r_mpos < 4'd4
                                    && b == hrhp_pkg::host_char(r_mpos);
                        n_mpos = w_mp1; w_part = hrhp_pkg::PT_KEY;
                    end
                end
                hrhp_pkg::PH_SPC: begin
                    if (b == 8'h20) n_phase = hrhp_pkg::PH_VAL0;
                    else begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                    end
                end
                hrhp_pkg::PH_VAL0, hrhp_pkg::PH_VAL: begin
                    if (r_phase == hrhp_pkg::PH_VAL0 && b == 8'h20) begin
                        w_part = hrhp_pkg::PT_DELIM;
                    end else if (b == 8'h0A
                                 || (r_phase == hrhp_pkg::PH_VAL0 && b == 8'h0D)) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                    end else if (b == 8'h0D) begin
                        if (r_cls == hrhp_pkg::HC_CLEN && !r_dig) begin
                            w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                        end else begin
                            if (r_cls == hrhp_pkg::HC_CLEN) n_len = r_neg ? ZERO_L : r_acc;
                            n_phase = hrhp_pkg::PH_LINELF;
                        end
                    end else begin
                        if (r_cls == hrhp_pkg::HC_CLEN) begin
                            if (r_dig) begin
                                if (!r_stop) begin
                                    if (w_isdig) n_acc = w_accx;
                                    else n_stop = 1'b1;
                                end
                            end else if (w_isdig) begin
                                n_acc = ZERO_L | LENGTH_WIDTH'(b[3:0]);
                                n_dig = 1'b1;
                                n_stop = 1'b0;
                            end else if (r_stop) begin
                                w_lenok = 1'b0;
                            end else if (b == 8'h20 || b == 8'h09 || b == 8'h0B
                                         || b == 8'h0C) begin
                                w_lenok = 1'b1;
                            end else if (b == "+") begin
                                n_stop = 1'b1;
                            end else if (b == "-") begin
                                n_stop = 1'b1; n_neg = 1'b1;
                            end else begin
                                w_lenok = 1'b0;
                            end
                        end
                        if (!w_lenok) begin
                            n_acc = r_acc; n_dig = r_dig; n_stop = r_stop; n_neg = r_neg;
                            w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                        end else begin
                            n_phase = hrhp_pkg::PH_VAL; w_part = hrhp_pkg::PT_VALUE;
                        end
                    end
                end
                hrhp_pkg::PH_LINELF: begin
                    if (b == 8'h0A) begin
                        n_phase = hrhp_pkg::PH_KEY0; n_cls = hrhp_pkg::HC_OTHER;
                    end else begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                    end
                end
                hrhp_pkg::PH_ENDLF: begin
                    if (b != 8'h0A) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_HDR;
                    end else if (r_len == ZERO_L) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_OK;
                    end else if (32'(r_max_body) < 32'(r_len)) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_TOO_LONG;
                    end else begin
                        n_rem = r_len; n_phase = hrhp_pkg::PH_BODY;
                    end
                end
                hrhp_pkg::PH_BODY: begin
                    w_part = hrhp_pkg::PT_BODY;
                    n_rem = (r_rem == ZERO_L) ? ZERO_L : r_rem - ONE_L;
                    if (n_rem == ZERO_L) begin
                        w_fin = 1'b1; w_st = hrhp_pkg::ST_OK;
                    end
                end
                default: begin
                    w_fin = 1'b1; w_st = hrhp_pkg::ST_BAD_LINE;
                end
            endcase
            if (w_fin && w_st != hrhp_pkg::ST_OK) w_part = hrhp_pkg::PT_DELIM;
        end

        w_res.done_res     = w_fin;
        w_res.status_code  = w_st;
        w_res.method       = n_meth;
        w_res.part         = w_part;
        w_res.header_class = n_cls;
        if (LENGTH_WIDTH > 16 && (n_len >> 16) != ZERO_L) begin
            w_res.content_length = 16'hFFFF;
        end else begin
            w_res.content_length = 16'(n_len);
        end
        w_res.byte_out     = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrhp_pkg::PH_METHOD; r_mpos <= 4'd0; r_meth <= 1'b0;
            r_cand <= 3'b111; r_cls <= hrhp_pkg::HC_OTHER; r_len <= ZERO_L;
            r_acc <= ZERO_L; r_neg <= 1'b0; r_dig <= 1'b0; r_stop <= 1'b0;
            r_rem <= ZERO_L; r_max_body <= hrhp_pkg::MAX_BODY_RESET;
            r_skid_v <= 1'b0; r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_body <= i_cfg_data;
            if (w_go) begin
                if (w_fin) begin
                    r_phase <= hrhp_pkg::PH_METHOD; r_mpos <= 4'd0; r_meth <= 1'b0;
                    r_cand <= 3'b111; r_cls <= hrhp_pkg::HC_OTHER; r_len <= ZERO_L;
                    r_acc <= ZERO_L; r_neg <= 1'b0; r_dig <= 1'b0; r_stop <= 1'b0;
                    r_rem <= ZERO_L;
                end else begin
                    r_phase <= n_phase; r_mpos <= n_mpos; r_meth <= n_meth;
                    r_cand <= n_cand; r_cls <= n_cls; r_len <= n_len; r_acc <= n_acc;
                    r_neg <= n_neg; r_dig <= n_dig; r_stop <= n_stop; r_rem <= n_rem;
                end
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
            // skid fills when a transfer in arrives and cannot be processed
            if (r_skid_v) begin
                if (w_go) r_skid_v <= 1'b0;
            end else if (i_valid && !w_go) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) r_out <= w_res;
        if (!r_skid_v && i_valid && !w_go) r_skid <= i_in;
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_fin_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && w_fin |=> r_phase == hrhp_pkg::PH_METHOD && r_mpos == 4'd0)
        else $error("parser did not restart after finish");
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.done_res |-> o_out.status_code == hrhp_pkg::ST_OK)
        else $error("status without done");
`endif

endmodule
`default_nettype wire
